FILE: hdl/wfbh_pkg.sv
// Shared constants and types for the word filter and bucket hash core.
`default_nettype none
package wfbh_pkg;

  localparam int unsigned MAX_WORD_LENGTH = 255;
  localparam int unsigned LEN_W           = $clog2(MAX_WORD_LENGTH + 2);
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] HASH_PRIME      = 32'h0100_0193;
  localparam logic [15:0] DEFAULT_BUCKETS = 16'd7919;
  localparam logic [7:0]  MAX_LETTERS_RST = 8'd16;
  localparam logic [LEN_W-1:0] MIN_LENGTH = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_SAT    = LEN_W'(MAX_WORD_LENGTH + 1);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_WORD_LENGTH);

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_Z = 8'h7a;
  localparam logic [7:0] CH_Q = 8'h71;
  localparam logic [7:0] CH_U = 8'h75;

  typedef enum logic [0:0] {
    REG_MAX_LETTERS  = 1'b0,
    REG_BUCKET_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        qualifies;
    logic [31:0] hash_value;
    logic [7:0]  trimmed_length;
  } word_rec_t;

endpackage
`default_nettype wire

FILE: hdl/wfbh_if.sv
// Valid/ready channel interfaces for character input and word results.
`default_nettype none
interface wfbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface wfbh_out_if;
  logic        valid;
  logic        ready;
  logic        qualifies;
  logic [31:0] hash_value;
  logic [15:0] bucket;
  logic [7:0]  trimmed_length;

  modport source (output valid, output qualifies, output hash_value, output bucket,
                  output trimmed_length, input ready);
  modport sink   (input valid, input qualifies, input hash_value, input bucket,
                  input trimmed_length, output ready);
endinterface
`default_nettype wire

FILE: hdl/word_filter_and_bucket_hash_core.sv
// Top level: word filter with FNV-style hash and bucket modulo.
//
//   channel   dir  fields                                       transaction when
//   in_ch     in   char_in[7:0], last_char                      valid && ready
//   out_ch    out  qualifies, hash_value[31:0], bucket[15:0],   valid && ready
//                  trimmed_length[7:0]
//   cfg       in   cfg_index (0 max_letters, 1 bucket_count)    cfg_write
//
// Bytes are taken one per cycle; in_ch.ready drops only while the record queue is full.
// The front hashes each byte, except a u after a q, with one multiply and XOR. The back
// loads a word in IDLE, runs 32 remainder steps in DIV, registers the result in DONE and
// only then takes another, so a 4-entry queue buffers words. Reset is synchronous; no clearing pass.
`default_nettype none
module word_filter_and_bucket_hash_core
  import wfbh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  wfbh_in_if.sink          in_ch,
  wfbh_out_if.source       out_ch
);

  logic [7:0]  max_letters;
  logic [15:0] bucket_count;
  logic        f_valid, f_ready;
  word_rec_t   f_rec;
  logic        b_valid, b_ready;
  word_rec_t   b_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_letters  <= MAX_LETTERS_RST;
      bucket_count <= DEFAULT_BUCKETS;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_LETTERS:  max_letters  <= cfg_data[7:0];
        REG_BUCKET_COUNT: bucket_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wfbh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .max_letters (max_letters),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .char_in     (in_ch.char_in),
    .last_char   (in_ch.last_char),
    .rec_valid   (f_valid),
    .rec_ready   (f_ready),
    .rec         (f_rec)
  );

  wfbh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_rec   (f_rec),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_rec    (b_rec)
  );

  wfbh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .bucket_count   (bucket_count),
    .rec_valid      (b_valid),
    .rec_ready      (b_ready),
    .rec            (b_rec),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .qualifies      (out_ch.qualifies),
    .hash_value     (out_ch.hash_value),
    .bucket         (out_ch.bucket),
    .trimmed_length (out_ch.trimmed_length)
  );

endmodule
`default_nettype wire

FILE: hdl/wfbh_front.sv
// Per-byte word checker and running hash; emits one record per word.
`default_nettype none
module wfbh_front
  import wfbh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] max_letters,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       last_char,
  output logic            rec_valid,
  input  wire logic       rec_ready,
  output word_rec_t       rec
);

  logic [31:0]      running_hash, running_hash_next;
  logic [LEN_W-1:0] raw_length, raw_length_next;
  logic [LEN_W-1:0] letter_count, letter_count_next;
  logic             after_q, after_q_next;
  logic             failed, failed_next;
  logic             accept;

  assign in_ready  = rec_ready;
  assign accept    = in_valid && in_ready;
  assign rec_valid = accept && last_char;

  always_comb begin
    raw_length_next   = (raw_length == LEN_SAT) ? raw_length : raw_length + LEN_W'(1);
    letter_count_next = letter_count;
    running_hash_next = running_hash;
    after_q_next      = 1'b0;
    failed_next       = failed;
    if (!(char_in inside {[CH_A:CH_Z]})) begin
      failed_next = 1'b1;
    end
    if (after_q) begin
      if (char_in != CH_U) begin
        failed_next = 1'b1;
      end
    end else begin
      running_hash_next = (running_hash * HASH_PRIME) ^ {24'd0, char_in};
      letter_count_next = (letter_count == LEN_SAT) ? letter_count
                                                   : letter_count + LEN_W'(1);
      after_q_next      = (char_in == CH_Q);
    end

    rec.hash_value     = running_hash_next;
    rec.trimmed_length = (letter_count_next > LEN_W'(255)) ? 8'd255 : letter_count_next[7:0];
    rec.qualifies      = !failed_next && !after_q_next
                         && (raw_length_next >= MIN_LENGTH)
                         && (raw_length_next <= LEN_MAX)
                         && (letter_count_next <= {{(LEN_W-8){1'b0}}, max_letters});
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      running_hash <= HASH_PRIME;
      raw_length   <= '0;
      letter_count <= '0;
      after_q      <= 1'b0;
      failed       <= 1'b0;
    end else if (accept) begin
      running_hash <= running_hash_next;
      raw_length   <= raw_length_next;
      letter_count <= letter_count_next;
      after_q      <= after_q_next;
      failed       <= failed_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/wfbh_queue.sv
// Small register queue of finished word records between front and back.
`default_nettype none
module wfbh_queue
  import wfbh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire word_rec_t push_rec,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output word_rec_t      pop_rec
);

  word_rec_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/wfbh_back.sv
// Bit-serial hash modulo bucket count and the registered result stage.
`default_nettype none
module wfbh_back
  import wfbh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] bucket_count,
  input  wire logic        rec_valid,
  output logic             rec_ready,
  input  wire word_rec_t   rec,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             qualifies,
  output logic [31:0]      hash_value,
  output logic [15:0]      bucket,
  output logic [7:0]       trimmed_length
);

  typedef enum logic [1:0] {
    IDLE,
    DIV,
    DONE
  } state_t;

  state_t      state;
  word_rec_t   held;
  logic [31:0] dividend;
  logic [15:0] rem;
  logic [15:0] divisor;
  logic [4:0]  bit_cnt;
  logic [16:0] rem_shift;
  logic [16:0] rem_sub;
  logic        load;

  assign rec_ready = (state == IDLE);
  assign rem_shift = {rem, dividend[31]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign load      = (state == DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (rec_valid) begin
            held     <= rec;
            dividend <= rec.hash_value;
            rem      <= '0;
            divisor  <= (bucket_count == '0) ? DEFAULT_BUCKETS : bucket_count;
            bit_cnt  <= '0;
            state    <= DIV;
          end
        end
        DIV: begin
          rem      <= rem_sub[16] ? rem_shift[15:0] : rem_sub[15:0];
          dividend <= {dividend[30:0], 1'b0};
          bit_cnt  <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (load) begin
            qualifies      <= held.qualifies;
            hash_value     <= held.hash_value;
            bucket         <= rem;
            trimmed_length <= held.trimmed_length;
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    load |-> (rem < divisor))
    else $error("remainder not below divisor at result load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == DIV && bit_cnt == 5'd31) |=> (state == DONE))
    else $error("division did not finish after 32 steps");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_ready) |=> (state == DIV && bit_cnt == 5'd0))
    else $error("record taken outside idle");
`endif

endmodule
`default_nettype wire
